@@ design/sfp_pkg.sv @@
// Shared types and constants for the sync frame parser with additive checksum.
// No dependencies; imported by sfp_front, sfp_back and the top level.
`default_nettype none

package sfp_pkg;

   localparam int PayloadMax   = 64;
   localparam int StoreAw      = $clog2(PayloadMax);
   localparam int LenW         = 7;
   localparam int DescDepth    = 2;
   localparam int DescPtrW     = 1;
   localparam int DescCntW     = 2;
   localparam int RspFifoDepth = 4;
   localparam int RspPtrW      = 2;
   localparam int RspCntW      = 3;

   // command codes on req_cmd
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   // CSR indexes
   localparam logic [1:0] CSR_SYNC1   = 2'd0;
   localparam logic [1:0] CSR_SYNC2   = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT = 2'd2;

   localparam logic [7:0]  SYNC1_RST   = 8'd170;
   localparam logic [7:0]  SYNC2_RST   = 8'd85;
   localparam logic [15:0] TIMEOUT_RST = 16'd100;

   typedef enum logic [3:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_SEQ_LO,
      PH_SEQ_HI,
      PH_TYPE,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY,
      PH_SUM
   } phase_type;

   // header of a frame that passed its checksum
   typedef struct packed {
      logic [7:0]      frame_type;
      logic [15:0]     seq;
      logic [LenW-1:0] len;
   } desc_type;

   typedef struct packed {
      logic               en;
      logic [StoreAw-1:0] addr;
      logic [7:0]         data;
   } store_wr_type;

   typedef struct packed {
      logic busy;
      logic empty;
   } back_sts_type;

   typedef struct packed {
      logic [7:0]      frame_type;
      logic [15:0]     seq;
      logic [LenW-1:0] payload_len;
      logic [7:0]      payload_byte;
      logic            byte_valid;
      logic            last;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/sfp_front.sv @@
// Front end: config registers, frame parser, idle timer, payload store writes.
// Depends on sfp_pkg; feeds sfp_back with store writes and frame descriptors.
`default_nettype none

module sfp_front
   import sfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [1:0]   cmd,
   input  wire logic [7:0]   byte_in,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output store_wr_type      store_wr,
   output logic              desc_push,
   output desc_type          desc
);

   logic [7:0]      sync1_ff, sync2_ff;
   logic [15:0]     idle_ticks_ff;

   phase_type       phase_ff, phase_in, eff_phase;
   logic [7:0]      sum_ff, sum_in;
   logic [15:0]     seq_ff, seq_in;
   logic [7:0]      type_ff, type_in;
   logic [7:0]      len_lo_ff, len_lo_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [LenW-1:0] idx_ff, idx_in, idx_inc;
   logic [15:0]     tmo_ff, tmo_in;
   logic            held_ff, held_in;

   logic            byte_go, tick_go, rel_go;
   logic [15:0]     len16;
   logic            len_bad;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync1_ff      <= SYNC1_RST;
         sync2_ff      <= SYNC2_RST;
         idle_ticks_ff <= TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC1:   sync1_ff      <= csr_wdata[7:0];
            CSR_SYNC2:   sync2_ff      <= csr_wdata[7:0];
            CSR_TIMEOUT: idle_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign byte_go = accept && (cmd == CMD_BYTE) && !held_ff;
   assign tick_go = accept && (cmd == CMD_TICK) && !held_ff;
   assign rel_go  = accept && (cmd == CMD_RELEASE) && held_ff;

   // idle timer ran out: byte is parsed as if hunting for sync
   assign eff_phase = (tmo_ff == '0) ? PH_SYNC1 : phase_ff;
   assign len16     = {byte_in, len_lo_ff};
   assign len_bad   = len16 > 16'(PayloadMax);
   assign idx_inc   = idx_ff + LenW'(1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (rel_go) begin
         phase_in = PH_SYNC1;
      end else if (byte_go) begin
         unique case (eff_phase)
            PH_SYNC2:  phase_in = (byte_in == sync2_ff) ? PH_SEQ_LO : PH_SYNC1;
            PH_SEQ_LO: phase_in = PH_SEQ_HI;
            PH_SEQ_HI: phase_in = PH_TYPE;
            PH_TYPE:   phase_in = PH_LEN_LO;
            PH_LEN_LO: phase_in = PH_LEN_HI;
            PH_LEN_HI: begin
               if (len_bad)
                  phase_in = PH_SYNC1;
               else if (len16 != '0)
                  phase_in = PH_BODY;
               else
                  phase_in = PH_SUM;
            end
            PH_BODY:   phase_in = (idx_inc >= len_ff) ? PH_SUM : PH_BODY;
            PH_SUM:    phase_in = PH_SYNC1;
            default:   phase_in = (byte_in == sync1_ff) ? PH_SYNC2 : PH_SYNC1;
         endcase
      end
   end

   // datapath updates
   always_comb begin
      sum_in    = sum_ff;
      seq_in    = seq_ff;
      type_in   = type_ff;
      len_lo_in = len_lo_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      tmo_in    = tmo_ff;
      held_in   = held_ff;
      store_wr  = '{en: 1'b0, addr: idx_ff[StoreAw-1:0], data: byte_in};
      desc_push = 1'b0;
      desc      = '{frame_type: type_ff, seq: seq_ff, len: len_ff};

      if (tick_go && tmo_ff != '0)
         tmo_in = tmo_ff - 16'd1;

      if (rel_go) begin
         held_in = 1'b0;
         tmo_in  = '0;
      end

      if (byte_go) begin
         tmo_in = idle_ticks_ff;
         unique case (eff_phase)
            PH_SYNC2: begin
               if (byte_in == sync2_ff)
                  sum_in = sum_ff + byte_in;
            end
            PH_SEQ_LO: begin
               seq_in = {8'h00, byte_in};
               sum_in = sum_ff + byte_in;
            end
            PH_SEQ_HI: begin
               seq_in = {byte_in, seq_ff[7:0]};
               sum_in = sum_ff + byte_in;
            end
            PH_TYPE: begin
               type_in = byte_in;
               sum_in  = sum_ff + byte_in;
            end
            PH_LEN_LO: begin
               len_lo_in = byte_in;
               sum_in    = sum_ff + byte_in;
            end
            PH_LEN_HI: begin
               if (!len_bad) begin
                  len_in = len16[LenW-1:0];
                  idx_in = '0;
                  sum_in = sum_ff + byte_in;
               end
            end
            PH_BODY: begin
               store_wr.en = 1'b1;
               idx_in      = idx_inc;
               sum_in      = sum_ff + byte_in;
            end
            PH_SUM: begin
               if (sum_ff == byte_in) begin
                  held_in   = 1'b1;
                  desc_push = 1'b1;
               end
            end
            default: begin
               if (byte_in == sync1_ff)
                  sum_in = byte_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         sum_ff    <= '0;
         seq_ff    <= '0;
         type_ff   <= '0;
         len_lo_ff <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         tmo_ff    <= '0;
         held_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         seq_ff    <= seq_in;
         type_ff   <= type_in;
         len_lo_ff <= len_lo_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         tmo_ff    <= tmo_in;
         held_ff   <= held_in;
      end
   end

endmodule

`default_nettype wire

@@ design/sfp_back.sv @@
// Back end: descriptor queue, payload store, replay sequencer, result FIFO.
// Depends on sfp_pkg; driven by sfp_front.
`default_nettype none

module sfp_back
   import sfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire store_wr_type store_wr,
   input  wire logic         desc_push,
   input  wire desc_type     desc,
   input  wire logic         rsp_pop,
   output back_sts_type      sts,
   output rsp_type           rsp
);

   logic [7:0]          store_mem [PayloadMax];

   desc_type            dq_ff [DescDepth];
   logic [DescPtrW-1:0] dq_wp_ff, dq_rp_ff;
   logic [DescCntW-1:0] dq_cnt_ff, dq_cnt_in;

   logic                active_ff, active_in;
   desc_type            cur_ff;
   logic [LenW-1:0]     k_ff, k_in;

   logic                pend_ff;
   rsp_type             pend_rsp_ff;
   logic [7:0]          rd_data_ff;

   rsp_type             fifo_ff [RspFifoDepth];
   logic [RspPtrW-1:0]  fifo_wp_ff, fifo_rp_ff;
   logic [RspCntW-1:0]  fifo_cnt_ff, fifo_cnt_in;

   logic                start, issue, issue_last, credit, fifo_push, fifo_pop;
   rsp_type             issue_rsp, fifo_wdata;

   // payload store: one write, one registered read
   always_ff @(posedge clock) begin
      if (store_wr.en)
         store_mem[store_wr.addr] <= store_wr.data;
   end

   always_ff @(posedge clock) begin
      if (issue)
         rd_data_ff <= store_mem[k_ff[StoreAw-1:0]];
   end

   // descriptor queue
   assign start = !active_ff && (dq_cnt_ff != '0);

   always_comb begin
      dq_cnt_in = dq_cnt_ff;
      if (desc_push && !start)
         dq_cnt_in = dq_cnt_ff + DescCntW'(1);
      else if (!desc_push && start)
         dq_cnt_in = dq_cnt_ff - DescCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (desc_push)
         dq_ff[dq_wp_ff] <= desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dq_wp_ff  <= '0;
         dq_rp_ff  <= '0;
         dq_cnt_ff <= '0;
      end else begin
         if (desc_push)
            dq_wp_ff <= dq_wp_ff + DescPtrW'(1);
         if (start)
            dq_rp_ff <= dq_rp_ff + DescPtrW'(1);
         dq_cnt_ff <= dq_cnt_in;
      end
   end

   // replay sequencer: one store read per cycle while the FIFO has room
   assign credit     = (fifo_cnt_ff + RspCntW'(pend_ff)) < RspCntW'(RspFifoDepth);
   assign issue      = active_ff && credit;
   assign issue_last = (cur_ff.len == '0) || ((k_ff + LenW'(1)) == cur_ff.len);

   always_comb begin
      active_in = active_ff;
      k_in      = k_ff;
      if (start) begin
         active_in = 1'b1;
         k_in      = '0;
      end else if (issue) begin
         k_in = k_ff + LenW'(1);
         if (issue_last)
            active_in = 1'b0;
      end
   end

   always_comb begin
      issue_rsp.frame_type   = cur_ff.frame_type;
      issue_rsp.seq          = cur_ff.seq;
      issue_rsp.payload_len  = cur_ff.len;
      issue_rsp.payload_byte = '0;
      issue_rsp.byte_valid   = cur_ff.len != '0;
      issue_rsp.last         = issue_last;
   end

   always_ff @(posedge clock) begin
      if (start)
         cur_ff <= dq_ff[dq_rp_ff];
      if (issue)
         pend_rsp_ff <= issue_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         k_ff      <= '0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         k_ff      <= k_in;
         pend_ff   <= issue;
      end
   end

   // result FIFO
   assign fifo_push = pend_ff;
   assign fifo_pop  = rsp_pop && (fifo_cnt_ff != '0);

   always_comb begin
      fifo_wdata = pend_rsp_ff;
      if (pend_rsp_ff.byte_valid)
         fifo_wdata.payload_byte = rd_data_ff;
   end

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (fifo_push && !fifo_pop)
         fifo_cnt_in = fifo_cnt_ff + RspCntW'(1);
      else if (!fifo_push && fifo_pop)
         fifo_cnt_in = fifo_cnt_ff - RspCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (fifo_push)
         fifo_ff[fifo_wp_ff] <= fifo_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wp_ff  <= '0;
         fifo_rp_ff  <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_push)
            fifo_wp_ff <= fifo_wp_ff + RspPtrW'(1);
         if (fifo_pop)
            fifo_rp_ff <= fifo_rp_ff + RspPtrW'(1);
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   assign rsp       = fifo_ff[fifo_rp_ff];
   assign sts.busy  = active_ff || (dq_cnt_ff != '0);
   assign sts.empty = fifo_cnt_ff == '0;

endmodule

`default_nettype wire

@@ design/sync_frame_parser_sum_check_top.sv @@
// A good frame's descriptor is queued on its checksum byte, then its replay registers
//   store reads into the result FIFO, stalling while that FIFO has no room.
// Throughput: one transaction per cycle on req_ while no frame is replaying (full is
//   high during a replay); results leave at one per cycle given pop.
// Reset: synchronous, active high; parser hunts for first sync, CSRs return to defaults,
//   payload store is not cleared.
`default_nettype none

module sync_frame_parser_sum_check_top
   import sfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,

   // input transactions
   input  wire logic         push,
   output logic              full,
   input  wire logic [1:0]   req_cmd,
   input  wire logic [7:0]   req_byte_in,

   // result transactions
   output logic              empty,
   input  wire logic         pop,
   output logic [7:0]        rsp_frame_type,
   output logic [15:0]       rsp_sequence_res,
   output logic [LenW-1:0]   rsp_payload_len,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last,

   // configuration
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   // Front parses one transaction per cycle while full is low. On a good checksum
   // it pushes a descriptor and the back end replays the payload store. full covers
   // the replay so no new payload can overwrite the store mid-read.
   store_wr_type  store_wr;
   logic          desc_push;
   desc_type      desc;
   back_sts_type  back_sts;
   rsp_type       rsp;
   logic          accept;

   assign accept = push && !full;
   assign full   = back_sts.busy;
   assign empty  = back_sts.empty;

   sfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .byte_in   (req_byte_in),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .store_wr  (store_wr),
      .desc_push (desc_push),
      .desc      (desc)
   );

   sfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .store_wr  (store_wr),
      .desc_push (desc_push),
      .desc      (desc),
      .rsp_pop   (pop),
      .sts       (back_sts),
      .rsp       (rsp)
   );

   assign rsp_frame_type   = rsp.frame_type;
   assign rsp_sequence_res = rsp.seq;
   assign rsp_payload_len  = rsp.payload_len;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_byte_valid   = rsp.byte_valid;
   assign rsp_last         = rsp.last;

`ifndef SYNTHESIS
   // a descriptor always starts a replay
   a_desc_starts_replay: assert property (@(posedge clock) disable iff (reset)
      desc_push |=> back_sts.busy)
      else $error("descriptor pushed but back end not busy");

   // the store is never written while a replay may still read it
   a_no_store_overwrite: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> !back_sts.busy)
      else $error("payload store written during replay");

   // an empty-frame result is a single zero byte marked last
   a_empty_frame_rsp: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_byte_valid) |-> (rsp_payload_byte == 8'h00 && rsp_last &&
      rsp_payload_len == '0))
      else $error("malformed empty-frame transaction");
`endif

endmodule

`default_nettype wire

@@ tb/frame_check_pkg.sv @@
// Frame tracker for the sync frame parser testbench: a cycle-free predictor of
// parse state plus the queue of payload replays it expects. Depends on sfp_pkg.
package frame_check_pkg;
   import sfp_pkg::*;

   class frame_tracker;
      logic [7:0]      sync1;
      logic [7:0]      sync2;
      logic [15:0]     idle_ticks;
      phase_type       parse_at;
      logic [7:0]      sum;
      logic [7:0]      ftype;
      logic [15:0]     seq_num;
      logic [15:0]     len_field;
      logic [LenW-1:0] body_idx;
      logic [7:0]      store [PayloadMax];
      logic [15:0]     ticks_left;
      bit              held;
      rsp_type         replay_q [$];
      int              errors;
      int              total_expected;

      function new();
         sync1          = SYNC1_RST;
         sync2          = SYNC2_RST;
         idle_ticks     = TIMEOUT_RST;
         parse_at       = PH_SYNC1;
         sum            = '0;
         ftype          = '0;
         seq_num        = '0;
         len_field      = '0;
         body_idx       = '0;
         ticks_left     = '0;
         held           = 1'b0;
         errors         = 0;
         total_expected = 0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 100) $display("ERROR: %s", msg);
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_SYNC1:   sync1 = value[7:0];
            CSR_SYNC2:   sync2 = value[7:0];
            CSR_TIMEOUT: idle_ticks = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return replay_q.size();
      endfunction

      // one accepted input transaction; queues the replay of a good frame
      function void note_item(logic [1:0] cmd, logic [7:0] b);
         rsp_type r;
         case (cmd)
            CMD_BYTE: begin
               if (held) return;
               if (ticks_left == 0) parse_at = PH_SYNC1;
               ticks_left = idle_ticks;
               case (parse_at)
                  PH_SYNC2: begin
                     if (b != sync2) begin
                        parse_at = PH_SYNC1;
                     end else begin
                        sum += b;
                        parse_at = PH_SEQ_LO;
                     end
                  end
                  PH_SEQ_LO: begin
                     seq_num = {8'h00, b};
                     sum += b;
                     parse_at = PH_SEQ_HI;
                  end
                  PH_SEQ_HI: begin
                     seq_num[15:8] = b;
                     sum += b;
                     parse_at = PH_TYPE;
                  end
                  PH_TYPE: begin
                     ftype = b;
                     sum += b;
                     parse_at = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     len_field = {8'h00, b};
                     sum += b;
                     parse_at = PH_LEN_HI;
                  end
                  PH_LEN_HI: begin
                     len_field[15:8] = b;
                     if (len_field > PayloadMax) begin
                        parse_at = PH_SYNC1;
                     end else begin
                        body_idx = '0;
                        sum += b;
                        parse_at = (len_field != 0) ? PH_BODY : PH_SUM;
                     end
                  end
                  PH_BODY: begin
                     if (body_idx < PayloadMax) store[body_idx[StoreAw-1:0]] = b;
                     body_idx = body_idx + 1'b1;
                     sum += b;
                     if (body_idx >= len_field || body_idx >= PayloadMax) parse_at = PH_SUM;
                  end
                  PH_SUM: begin
                     parse_at = PH_SYNC1;
                     if (sum == b) begin
                        held = 1'b1;
                        r.frame_type = ftype;
                        r.seq        = seq_num;
                        if (len_field == 0) begin
                           r.payload_len  = '0;
                           r.payload_byte = '0;
                           r.byte_valid   = 1'b0;
                           r.last         = 1'b1;
                           replay_q.push_back(r);
                           total_expected++;
                        end else begin
                           for (int k = 0; k < len_field; k++) begin
                              r.payload_len  = len_field[LenW-1:0];
                              r.payload_byte = store[k];
                              r.byte_valid   = 1'b1;
                              r.last         = (k == len_field - 1);
                              replay_q.push_back(r);
                              total_expected++;
                           end
                        end
                     end
                  end
                  default: begin
                     if (b == sync1) begin
                        sum = b;
                        parse_at = PH_SYNC2;
                     end else begin
                        parse_at = PH_SYNC1;
                     end
                  end
               endcase
            end
            CMD_TICK: begin
               if (!held && ticks_left != 0) ticks_left--;
            end
            CMD_RELEASE: begin
               if (held) begin
                  held = 1'b0;
                  ticks_left = '0;
                  parse_at = PH_SYNC1;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (replay_q.size() == 0) begin
            report($sformatf("result with nothing expected: type %h seq %h len %0d byte %h",
                             got.frame_type, got.seq, got.payload_len, got.payload_byte));
            return;
         end
         want = replay_q.pop_front();
         if (got !== want)
            report($sformatf({"result mismatch: got type %h seq %h len %0d byte %h v%b l%b,",
                              " want type %h seq %h len %0d byte %h v%b l%b"},
                             got.frame_type, got.seq, got.payload_len, got.payload_byte,
                             got.byte_valid, got.last, want.frame_type, want.seq,
                             want.payload_len, want.payload_byte, want.byte_valid, want.last));
      endfunction

      function void wrap_up();
         if (replay_q.size() != 0)
            report($sformatf("%0d expected results never arrived", replay_q.size()));
      endfunction
   endclass

endpackage

@@ tb/sync_frame_parser_sum_check_top_test.sv @@
// Top-level testbench for sync_frame_parser_sum_check_top: directed frames, then
// random well-formed and broken frames over several CSR settings, under backpressure.
// Depends on sfp_pkg, frame_check_pkg and the RTL.
module sync_frame_parser_sum_check_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sfp_pkg::*;
   import frame_check_pkg::*;

   // cycles to let the pipeline settle before a CSR write or the final verdict
   localparam int SETTLE_CYCLES = 12;

   // how a generated frame gets broken, if at all
   typedef enum int {
      FLAW_NONE,
      FLAW_SYNC2,
      FLAW_LEN,
      FLAW_SUM,
      FLAW_CUT
   } flaw_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              push;
   logic              full;
   logic [1:0]        req_cmd;
   logic [7:0]        req_byte_in;
   logic              empty;
   logic              pop;
   logic [7:0]        rsp_frame_type;
   logic [15:0]       rsp_sequence_res;
   logic [LenW-1:0]   rsp_payload_len;
   logic [7:0]        rsp_payload_byte;
   logic              rsp_byte_valid;
   logic              rsp_last;
   logic              csr_wr_en;
   logic [1:0]        csr_index;
   logic [15:0]       csr_wdata;

   frame_tracker      tracker;

   // sender pacing
   int                burst_left = 0;
   bit                gaps_on = 1'b1;
   int                items_sent = 0;

   // receiver pacing: a rotating pop mask, plus a long hold counted down below
   logic [15:0]       rx_pattern = 16'hFFFF;
   logic [3:0]        rx_slot = '0;
   int                rx_hold = 0;

   always #5 clock = ~clock;

   sync_frame_parser_sum_check_top DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_byte_in      (req_byte_in),
      .empty            (empty),
      .pop              (pop),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one input transaction and wait until it is taken. Push stays high
   // after acceptance so back-to-back items never drop it within a step; it is
   // only lowered at the start of a gap or by drain().
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      push        <= 1'b1;
      req_cmd     <= cmd;
      req_byte_in <= b;
      do @(posedge clock); while (full);
      tracker.note_item(cmd, b);
      burst_left--;
   endtask

   // Sender goes quiet until every expected result has been popped, then lets
   // the pipeline settle.
   task automatic drain();
      int spins;
      spins = 0;
      push <= 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0 && spins < 200000) begin
         @(posedge clock);
         spins++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   // Only called with the block idle. Upper bits of the 8-bit registers carry
   // junk on purpose; they must be dropped.
   task automatic configure(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] idle_ticks);
      csr_write(CSR_SYNC1, {rand_byte(), s1});
      csr_write(CSR_SYNC2, {rand_byte(), s2});
      csr_write(CSR_TIMEOUT, idle_ticks);
      csr_wr_en <= 1'b0;
   endtask

   // One frame in byte order with a correct or broken field. With a length
   // flaw only the header goes out, since the parser drops out at length high.
   // tick_odds > 0 scatters timer ticks in between bytes (1 in tick_odds).
   task automatic send_frame(input logic [15:0] seq_val, input logic [7:0] ftype,
                             input logic [15:0] len_field, input flaw_type flaw,
                             input int tick_odds);
      logic [7:0] fb [$];
      logic [7:0] sum;
      int         stop_at;
      fb = '{tracker.sync1, tracker.sync2, seq_val[7:0], seq_val[15:8], ftype,
             len_field[7:0], len_field[15:8]};
      if (flaw == FLAW_SYNC2) fb[1] = tracker.sync2 ^ 8'($urandom_range(1, 255));
      if (flaw != FLAW_LEN) begin
         repeat (len_field) fb.push_back(rand_byte());
         sum = '0;
         foreach (fb[i]) sum += fb[i];
         if (flaw == FLAW_SUM) sum ^= 8'($urandom_range(1, 255));
         fb.push_back(sum);
      end
      stop_at = (flaw == FLAW_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
      for (int i = 0; i < stop_at; i++) begin
         if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) begin
            repeat ($urandom_range(1, 3)) begin
               send_item(CMD_TICK, rand_byte());
               items_sent++;
            end
         end
         send_item(CMD_BYTE, fb[i]);
         items_sent++;
      end
   endtask

   // Mostly good frames with random content; the rest broken in one place.
   // Lengths stay small except now and then a full 64-byte payload.
   task automatic random_frame(input int tick_odds);
      logic [15:0] len_field;
      flaw_type    flaw;
      int          roll;
      roll = $urandom_range(0, 15);
      case (roll)
         10:      flaw = FLAW_SYNC2;
         11:      flaw = FLAW_LEN;
         12:      flaw = FLAW_SUM;
         13:      flaw = FLAW_CUT;
         default: flaw = FLAW_NONE;
      endcase
      if (flaw == FLAW_LEN)
         len_field = $urandom_range(0, 1) ? 16'($urandom_range(PayloadMax + 1, 255))
                                          : 16'($urandom_range(256, 65535));
      else if ($urandom_range(0, 11) == 0)
         len_field = 16'(PayloadMax);
      else
         len_field = 16'($urandom_range(0, 8));
      send_frame(16'($urandom_range(0, 65535)), rand_byte(), len_field, flaw, tick_odds);
      // stray traffic while a good frame is held should change nothing
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3))
            send_item($urandom_range(0, 1) ? CMD_BYTE : CMD_TICK, rand_byte());
      send_item(CMD_RELEASE, rand_byte());
   endtask

   // Random traffic until n_items have gone out; the last phase also runs on
   // until a few dozen results are on record.
   task automatic random_phase(input int n_items, input int tick_odds, input bit want_results);
      int start;
      int roll;
      start = items_sent;
      while (items_sent - start < n_items || (want_results && tracker.total_expected < 48)) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               roll = $urandom_range(0, 5);
               send_item(roll < 4 ? CMD_BYTE : (roll == 4 ? CMD_TICK : CMD_RELEASE),
                         rand_byte());
               items_sent++;
            end
         end else begin
            random_frame(tick_odds);
         end
      end
   endtask

   // Receiver: check whatever was popped at this edge, then choose pop for the
   // next cycle from the hold counter or the rotating mask.
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty)
            tracker.check_rsp(rsp_type'{rsp_frame_type, rsp_sequence_res, rsp_payload_len,
                                        rsp_payload_byte, rsp_byte_valid, rsp_last});
         if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
         end else begin
            pop <= rx_pattern[rx_slot];
            rx_slot <= rx_slot + 1'b1;
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      tracker = new();
      reset       <= 1'b1;
      push        <= 1'b0;
      req_cmd     <= CMD_BYTE;
      req_byte_in <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_SYNC1;
      csr_wdata   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset CSR values.
      // release with nothing held and a tick with the idle timer already at zero
      send_item(CMD_RELEASE, 8'hFF);
      send_item(CMD_TICK, 8'h00);
      // wrong second sync: parser goes back to hunting
      send_item(CMD_BYTE, tracker.sync1);
      send_item(CMD_BYTE, 8'h00);
      // length one past the payload maximum
      send_frame(16'h0000, 8'h00, 16'(PayloadMax + 1), FLAW_LEN, 0);
      // empty frame with all-ones header fields
      send_frame(16'hFFFF, 8'hFF, 16'd0, FLAW_NONE, 0);
      // held: byte and tick ignored, then release
      send_item(CMD_BYTE, tracker.sync1);
      send_item(CMD_TICK, 8'hFF);
      send_item(CMD_RELEASE, 8'h00);
      drain();

      // Zero and all-ones sync bytes, shortest idle timeout.
      configure(8'h00, 8'hFF, 16'd1);
      rx_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
      // idle restart: a tick expires the timer between the two sync bytes, so
      // the next first sync must start a fresh frame
      send_item(CMD_BYTE, tracker.sync1);
      send_item(CMD_TICK, 8'h00);
      send_frame(16'h1234, 8'h01, 16'd1, FLAW_NONE, 0);
      send_item(CMD_RELEASE, 8'h00);
      random_phase(6, 12, 1'b0);
      drain();

      // Longest idle timeout. Receiver holds off while a max-length frame and
      // its release are offered, so the result side backs up and full rises.
      configure(8'hFF, 8'h00, 16'hFFFF);
      gaps_on    = 1'b0;
      rx_pattern = 16'hFFFF;
      rx_hold    = 400;
      send_frame(16'($urandom_range(0, 65535)), rand_byte(), 16'(PayloadMax), FLAW_NONE, 0);
      send_item(CMD_RELEASE, rand_byte());
      drain();

      // Random sync bytes, timeout short enough for scattered ticks to expire
      // it; sparse pops.
      configure(rand_byte(), rand_byte(), 16'd3);
      gaps_on    = 1'b1;
      rx_pattern = 16'h0101;
      random_phase(6, 4, 1'b0);
      drain();

      // Both sync bytes equal, default timeout, random pop mask.
      begin
         logic [7:0] same;
         same = rand_byte();
         configure(same, same, TIMEOUT_RST);
      end
      rx_pattern = 16'($urandom_range(0, 65535)) | 16'h8001;
      random_phase(8, 6, 1'b1);
      drain();

      tracker.wrap_up();
      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
